FILE: rtl/lpsp_pkg.sv
`default_nettype none

package lpsp_pkg;

    // Largest sub-block payload allowed by the format.
    localparam int MAX_BLOCK_DEF = 255;

    // Controller states, one-hot.
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EMIT = 2'b10
    } t_state;

    // Where an output byte of a sub-block sequence comes from.
    typedef enum logic [1:0] {
        SRC_HDR  = 2'b00,
        SRC_MEM  = 2'b01,
        SRC_ZERO = 2'b10
    } t_src;

endpackage

`default_nettype wire

FILE: rtl/length_prefixed_subblock_packer_unit.sv
`default_nettype none

// Sub-block packer: turns a byte stream into count-prefixed sub-blocks.
// Input channel (s_axis): one transfer carries one byte in tdata, with tuser = 0
// for a payload byte and tuser = 1 for a close of the stream.
// Output channel (m_axis): each transfer carries up to eight bytes, first byte in
// the low bits, plus the number of valid bytes; tlast marks the final transfer
// caused by one input.
// Payload bytes are stored in a single-port buffer memory, one per cycle while
// s_axis_tready is high, and cause no output until MAX_BLOCK bytes are held. The
// byte that fills the buffer, or a close, starts an emit pass that walks the
// sequence (count byte, stored bytes, terminator on close) one byte per cycle
// unless the output register stalls it, through the registered memory read port.
// s_axis_tready stays low for the pass and until its last byte has left the read
// stage, so no new byte is taken while a pass is still under way.
// An output register decouples the two sides: when the receiver stalls, the last
// finished word waits there while new payload bytes are still accepted, and an
// emit pass simply holds at the point where it needs the register.
// Reset (synchronous, active low) empties the buffer count and drops all pending
// output; the buffer contents themselves are not cleared and need not be.
module length_prefixed_subblock_packer_unit
    import lpsp_pkg::*;
#(
    parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tuser,   // [0] kind (1 = close stream)
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0]      m_axis_tdata,   // [63:0] out_bytes, [67:64] byte_count
    output logic             m_axis_tlast    // last_of_run
);

    // Count width holds 0..MAX_BLOCK, address width indexes the buffer, and
    // the sequence index covers count byte + payload + terminator.
    localparam int CW = $clog2(MAX_BLOCK + 1);
    localparam int AW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
    localparam int IW = $clog2(MAX_BLOCK + 3);

    // Buffer memory and its registered read data.
    logic [7:0]    r_mem [MAX_BLOCK];
    logic [7:0]    r_rd_data;

    // Control state.
    t_state        r_state, n_state;
    logic [CW-1:0] r_fill;
    logic [CW-1:0] r_len;
    logic          r_hdr;
    logic [IW-1:0] r_total;
    logic [IW-1:0] r_issue;

    // Read stage: one byte of the sequence in flight toward the assembler.
    logic          r_p_valid;
    t_src          r_p_src;
    logic          r_p_last;

    // Word assembler and output register.
    logic [63:0]   r_acc;
    logic [2:0]    r_acc_cnt;
    logic [63:0]   r_out_data;
    logic [3:0]    r_out_cnt;
    logic          r_out_last;
    logic          r_out_valid;

    logic          s_fire;
    logic          m_fire;
    logic          stall;
    logic          issue_ok;
    logic          block_full;
    logic [IW-1:0] data_idx;
    t_src          issue_src;
    logic          issue_last;
    logic [7:0]    p_byte;
    logic [63:0]   acc_new;
    logic          word_done;

    assign s_axis_tready = (r_state == S_EMIT) ? 1'b0 : !r_p_valid;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign m_fire        = r_out_valid && m_axis_tready;
    assign block_full    = (r_fill == CW'(MAX_BLOCK - 1));

    // A byte that closes a word can only move on if the output register frees up.
    assign word_done = (r_acc_cnt == 3'(7)) || r_p_last;
    assign stall     = r_p_valid && word_done && r_out_valid && !m_axis_tready;
    assign issue_ok  = (r_state == S_EMIT) && !stall;

    // Classify the next sequence byte: count byte, stored payload, or terminator.
    assign data_idx   = r_issue - IW'(r_hdr);
    assign issue_last = (r_issue == (r_total - IW'(1)));

    always_comb begin
        priority if (r_hdr && (r_issue == '0)) begin
            issue_src = SRC_HDR;
        end else if (data_idx < IW'(r_len)) begin
            issue_src = SRC_MEM;
        end else begin
            issue_src = SRC_ZERO;
        end
    end

    always_comb begin
        unique case (r_p_src)
            SRC_HDR:  p_byte = 8'(r_len);
            SRC_MEM:  p_byte = r_rd_data;
            default:  p_byte = 8'h00;
        endcase
    end

    // Drop the byte into its lane; lanes above stay zero.
    always_comb begin
        acc_new = r_acc;
        acc_new[r_acc_cnt*8 +: 8] = p_byte;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_fire && (s_axis_tuser || block_full)) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (issue_ok && issue_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Buffer write on payload transfers, synchronous read during emit.
    always_ff @(posedge i_clk) begin
        if (s_fire && !s_axis_tuser) begin
            r_mem[r_fill[AW-1:0]] <= s_axis_tdata;
        end
        if (issue_ok) begin
            r_rd_data <= r_mem[data_idx[AW-1:0]];
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            if (s_axis_tuser) begin
                r_len   <= r_fill;
                r_hdr   <= (r_fill != '0);
                r_total <= IW'(r_fill) + IW'(r_fill != '0) + IW'(1);
            end else begin
                r_len   <= CW'(MAX_BLOCK);
                r_hdr   <= 1'b1;
                r_total <= IW'(MAX_BLOCK + 1);
            end
        end
        if (issue_ok) begin
            r_p_src  <= issue_src;
            r_p_last <= issue_last;
        end
        if (r_p_valid && !stall && word_done) begin
            r_out_data <= acc_new;
            r_out_cnt  <= 4'(r_acc_cnt) + 4'd1;
            r_out_last <= r_p_last;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_issue     <= '0;
            r_p_valid   <= 1'b0;
            r_acc       <= '0;
            r_acc_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (s_fire) begin
                if (s_axis_tuser || block_full) begin
                    r_fill  <= '0;
                    r_issue <= '0;
                end else begin
                    r_fill <= r_fill + CW'(1);
                end
            end else if (issue_ok) begin
                r_issue <= r_issue + IW'(1);
            end

            if (!stall) begin
                r_p_valid <= issue_ok;
            end

            if (r_p_valid && !stall) begin
                if (word_done) begin
                    r_acc     <= '0;
                    r_acc_cnt <= '0;
                end else begin
                    r_acc     <= acc_new;
                    r_acc_cnt <= r_acc_cnt + 3'd1;
                end
            end

            if (r_p_valid && !stall && word_done) begin
                r_out_valid <= 1'b1;
            end else if (m_fire) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out_cnt, r_out_data};
    assign m_axis_tlast  = r_out_last;

`ifndef SYNTHESIS
    // The buffer count never reaches the block size; a full block empties it.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill < CW'(MAX_BLOCK))
        else $error("fill count reached block size");

    // The emit pass never runs past the end of its sequence.
    a_issue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_issue < r_total))
        else $error("emit index beyond sequence length");

    // A stalled read stage keeps its memory data.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stall |=> $stable(r_rd_data))
        else $error("read data changed during stall");

    // Between runs the word assembler is empty.
    a_acc_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire |-> (r_acc_cnt == '0))
        else $error("assembler not empty at input transfer");
`endif

endmodule

`default_nettype wire

FILE: test/tb.sv
module tb;
    import lpsp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_BLOCK = MAX_BLOCK_DEF;

    // Codes carried in s_axis_tuser.
    localparam logic KIND_DATA  = 1'b0;
    localparam logic KIND_CLOSE = 1'b1;

    // Cycles without any transfer on either side before the run is declared hung.
    // The byte that fills a block holds off the input side until its emit pass is done,
    // and random stalls come in short streaks, so this allows a large margin.
    localparam int HANG_LIMIT = 2000;
    // Quiet time after the last expected word, to catch any stray output.
    localparam int TAIL_CYCLES = 300;

    // One output word as the packer presents it.
    typedef struct packed {
        logic [63:0] out_bytes;
        logic [3:0]  byte_count;
        logic        last_of_run;
    } t_packed_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] data_byte
    logic        s_axis_tuser = 1'b0;    // [0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;           // [63:0] out_bytes, [67:64] byte_count
    logic        m_axis_tlast;           // last_of_run

    // Idle percentages of the sender and of the receiver.
    int unsigned tx_idle_pct = 19;
    int unsigned rx_idle_pct = 19;

    int unsigned error_count = 0;
    int unsigned quiet_cycles = 0;

    // Predictor state: the bytes held for the current sub-block and how many.
    logic [7:0]  held_bytes [MAX_BLOCK];
    int unsigned held_count = 0;

    // Words the packer still owes, oldest first.
    t_packed_word pending_words [$];

    length_prefixed_subblock_packer_unit #(
        .MAX_BLOCK(MAX_BLOCK)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // The receiver stalls at random, one decision per cycle.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Works out the words that one accepted transfer causes and queues them.
    // A payload byte is stored, and only the byte that fills the buffer releases
    // a block. A close releases the partial block, if there is one, and then the
    // zero terminator. In both cases the buffer starts over empty.
    task automatic predict_subblocks(input logic kind, input logic [7:0] value);
        logic [7:0]   stream [$];
        t_packed_word word;
        int unsigned  pos;
        int unsigned  take;
        bit           release_block;

        release_block = 1'b0;
        if (kind == KIND_DATA) begin
            held_bytes[held_count] = value;
            held_count++;
            release_block = (held_count >= MAX_BLOCK);
        end else begin
            release_block = (held_count > 0);
        end

        if (release_block) begin
            stream.push_back(8'(held_count));
            for (int i = 0; i < held_count; i++) begin
                stream.push_back(held_bytes[i]);
            end
        end
        if (kind == KIND_CLOSE) begin
            stream.push_back(8'h00);
        end
        if (kind == KIND_CLOSE || release_block) begin
            held_count = 0;
        end

        // Cut the byte sequence into words of up to eight bytes, first byte lowest.
        // Unused lanes stay zero, and only the final word carries last_of_run.
        pos = 0;
        while (pos < stream.size()) begin
            take = stream.size() - pos;
            if (take > 8) begin
                take = 8;
            end
            word = '0;
            for (int b = 0; b < take; b++) begin
                word.out_bytes[8*b +: 8] = stream[pos + b];
            end
            word.byte_count = 4'(take);
            pos += take;
            word.last_of_run = (pos >= stream.size());
            pending_words.push_back(word);
        end
    endtask

    // Sends one item on s_axis, after a random number of idle cycles. Valid stays
    // high after the transfer so that a following item can go out in the next
    // cycle. Callers lower it through release_input before they wait for anything.
    task automatic send_item(input logic kind, input logic [7:0] value);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= value;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        predict_subblocks(kind, value);
    endtask

    task automatic release_input();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Checker: every word accepted on m_axis must match the oldest expected word.
    always @(posedge i_clk) begin
        t_packed_word exp_word;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_words.size() == 0) begin
                error_count++;
                $display("%0t: unexpected word: expected none, actual bytes %h count %0d last %0b",
                         $time, m_axis_tdata[63:0], m_axis_tdata[67:64], m_axis_tlast);
            end else begin
                exp_word = pending_words.pop_front();
                if (m_axis_tdata[63:0] !== exp_word.out_bytes) begin
                    error_count++;
                    $display("%0t: out_bytes mismatch: expected %h actual %h",
                             $time, exp_word.out_bytes, m_axis_tdata[63:0]);
                end
                if (m_axis_tdata[67:64] !== exp_word.byte_count) begin
                    error_count++;
                    $display("%0t: byte_count mismatch: expected %0d actual %0d",
                             $time, exp_word.byte_count, m_axis_tdata[67:64]);
                end
                if (m_axis_tlast !== exp_word.last_of_run) begin
                    error_count++;
                    $display("%0t: last_of_run mismatch: expected %0b actual %0b",
                             $time, exp_word.last_of_run, m_axis_tlast);
                end
            end
        end
    end

    // Watchdog: counts cycles in which neither side completes a transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= HANG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d words still expected",
                     $time, HANG_LIMIT, pending_words.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Covers a close on an empty buffer and short partial blocks. The last two partial
    // blocks are sized so that the emitted sequence fits one word exactly, and then
    // spills by a single byte into a second word. Most closes carry a nonzero data
    // byte, which the packer must ignore.
    task automatic test_directed_closes();
        logic [7:0] pattern [7];

        pattern = '{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h01, 8'h80, 8'h7F};
        send_item(KIND_CLOSE, 8'hFF);

        send_item(KIND_DATA, 8'h00);
        send_item(KIND_CLOSE, 8'h3C);

        // Count byte, six data bytes and the terminator: exactly eight bytes.
        for (int i = 0; i < 6; i++) begin
            send_item(KIND_DATA, pattern[i]);
        end
        send_item(KIND_CLOSE, 8'h00);

        // Seven data bytes make nine bytes in total, so one byte goes into a second word.
        for (int i = 0; i < 7; i++) begin
            send_item(KIND_DATA, pattern[i]);
        end
        send_item(KIND_CLOSE, 8'hFF);
    endtask

    // Fills a whole block so that it goes out on its own. A close then follows
    // on the now empty buffer. A short block afterwards shows that the fill
    // count restarted at zero.
    task automatic test_full_block();
        for (int i = 0; i < MAX_BLOCK; i++) begin
            send_item(KIND_DATA, 8'($urandom));
        end
        send_item(KIND_CLOSE, 8'($urandom));
        for (int i = 0; i < 10; i++) begin
            send_item(KIND_DATA, 8'($urandom));
        end
        send_item(KIND_CLOSE, 8'($urandom));
    endtask

    // Random streams of bytes with occasional closes. The first half runs with
    // no idling on either side, and the second half with the usual random gaps.
    task automatic test_random_stream();
        for (int i = 0; i < 180; i++) begin
            if (i == 0) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else if (i == 90) begin
                tx_idle_pct = 19;
                rx_idle_pct = 19;
            end
            if ($urandom_range(0, 11) == 0) begin
                send_item(KIND_CLOSE, 8'($urandom));
            end else begin
                send_item(KIND_DATA, 8'($urandom));
            end
        end
        // Close the last stream so that the tail of the data is checked too.
        send_item(KIND_CLOSE, 8'($urandom));
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_closes();
        test_full_block();
        test_random_stream();
        release_input();

        // Let the packer drain, then watch for stray words for a while. The
        // watchdog catches a packer that never delivers what is still expected.
        while (pending_words.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: length_prefixed_subblock_packer_unit.f
rtl/lpsp_pkg.sv
rtl/length_prefixed_subblock_packer_unit.sv
test/tb.sv
